>>> rtl/core/lbct_pkg.sv
// Shared types, codes and sizes for the buffer cache tag manager.
package lbct_pkg;

  localparam int NUM_BUFFERS = 16;
  localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int CMP_W = (IDX_W > 4) ? IDX_W : 4;
  localparam logic [CMP_W:0] NB_LIMIT = (CMP_W + 1)'(NUM_BUFFERS);

  localparam logic [1:0] OP_GET       = 2'd0;
  localparam logic [1:0] OP_RELEASE   = 2'd1;
  localparam logic [1:0] OP_WRITE     = 2'd2;
  localparam logic [1:0] OP_DISK_DONE = 2'd3;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_RECYCLED = 3'd1;
  localparam logic [2:0] ST_WAIT     = 3'd2;
  localparam logic [2:0] ST_NO_BUF   = 3'd3;
  localparam logic [2:0] ST_NOT_BUSY = 3'd4;

  localparam logic [3:0] MK_BUSY     = 4'b0001;
  localparam logic [3:0] MK_VALID    = 4'b0010;
  localparam logic [3:0] MK_DIRTY    = 4'b0100;
  localparam logic [3:0] MK_ASSIGNED = 4'b1000;

  typedef struct packed {
    logic [IDX_W-1:0] id;
    logic [7:0]       device;
    logic [31:0]      sector;
    logic [3:0]       marks;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    logic hit;
    logic free;
    logic addr;
  } cell_flags_t;

  // Low four bits of an entry number, as reported on the result channel.
  function automatic logic [3:0] idx_out(input logic [IDX_W-1:0] id);
    logic [CMP_W-1:0] w;
    w = CMP_W'(id);
    return w[3:0];
  endfunction

endpackage

>>> rtl/core/lbct_cell.sv
// One recency position: holds the entry at that position and its tag compare.
module lbct_cell
  import lbct_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rst_id,
  input  cell_ctl_t        ctl,
  input  entry_t           prev_ent,
  input  entry_t           bus_ent,
  input  logic [7:0]       q_device,
  input  logic [31:0]      q_sector,
  input  logic [CMP_W-1:0] q_index,
  output entry_t           ent,
  output cell_flags_t      flags
);

  logic [IDX_W-1:0] id_r, id_nxt;
  logic [7:0]       dev_r, dev_nxt;
  logic [31:0]      sec_r, sec_nxt;
  logic [3:0]       marks_r, marks_nxt;

  always_comb begin
    priority if (ctl.shift) begin
      id_nxt    = prev_ent.id;
      dev_nxt   = prev_ent.device;
      sec_nxt   = prev_ent.sector;
      marks_nxt = prev_ent.marks;
    end else if (ctl.load) begin
      id_nxt    = bus_ent.id;
      dev_nxt   = bus_ent.device;
      sec_nxt   = bus_ent.sector;
      marks_nxt = bus_ent.marks;
    end else begin
      id_nxt    = id_r;
      dev_nxt   = dev_r;
      sec_nxt   = sec_r;
      marks_nxt = marks_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r    <= rst_id;
      marks_r <= '0;
    end else begin
      id_r    <= id_nxt;
      marks_r <= marks_nxt;
    end
  end

  // Tag payload needs no reset: an unassigned entry never matches.
  always_ff @(posedge clk) begin
    dev_r <= dev_nxt;
    sec_r <= sec_nxt;
  end

  assign ent.id     = id_r;
  assign ent.device = dev_r;
  assign ent.sector = sec_r;
  assign ent.marks  = marks_r;

  assign flags.hit  = ((marks_r & MK_ASSIGNED) != '0) && (dev_r == q_device) &&
                      (sec_r == q_sector);
  assign flags.free = (marks_r & (MK_BUSY | MK_DIRTY)) == '0;
  assign flags.addr = CMP_W'(id_r) == q_index;

endmodule

>>> rtl/core/lbct_pick.sv
// Selects the most recent matching position and the least recent free position.
module lbct_pick
  import lbct_pkg::*;
(
  input  logic [NUM_BUFFERS-1:0] hit_v,
  input  logic [NUM_BUFFERS-1:0] free_v,
  output logic [NUM_BUFFERS-1:0] hit_oh,
  output logic [NUM_BUFFERS-1:0] free_oh,
  output logic                   any_hit,
  output logic                   any_free
);

  logic [NUM_BUFFERS-1:0] free_rev;
  logic [NUM_BUFFERS-1:0] free_iso;

  // Isolate the lowest set bit; reverse to find the highest free position.
  assign hit_oh = hit_v & (~hit_v + NUM_BUFFERS'(1));

  always_comb begin
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      free_rev[i] = free_v[NUM_BUFFERS-1-i];
    end
  end

  assign free_iso = free_rev & (~free_rev + NUM_BUFFERS'(1));

  always_comb begin
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      free_oh[i] = free_iso[NUM_BUFFERS-1-i];
    end
  end

  assign any_hit  = |hit_v;
  assign any_free = |free_v;

endmodule

>>> rtl/core/lru_buffer_cache_tags.sv
// Top level of the buffer cache tag manager: request channel, cell chain, result register.
//
// Usage:
//   Requests enter on in_valid / in_stall with in_op, in_device, in_sector and
//   in_buffer_index. A transaction is taken at a clock edge where in_valid is
//   high and in_stall is low. Each request gives exactly one result on
//   out_valid / out_stall: out_status, out_entry_index, out_needs_read and
//   out_needs_write.
//   The block works on one request at a time, in turn: tag compare
//   in every cell, selection of the most recent hit or least recent free
//   entry, then the update of the chain together with the result register.
//   A new request is taken only once the last one's update is done.
//   The recency order lives in a chain of cells, one per position; a release
//   moves its entry to position 0 while the cells in front of it shift back
//   by one position, all in the same cycle.
//   Reset (rst_n low, synchronous) empties the cache: all marks clear and
//   position p holds entry NUM_BUFFERS-1-p. No clearing pass is needed.
//   When the receiver stalls, the result holds in the output register; a new
//   request is still taken and worked on, and its update waits until the
//   output register frees.
module lru_buffer_cache_tags
  import lbct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_device,
  input  logic [31:0] in_sector,
  input  logic [3:0]  in_buffer_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [3:0]  out_entry_index,
  output logic        out_needs_read,
  output logic        out_needs_write
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MATCH = 2'd1;
  localparam logic [1:0] S_PICK  = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  logic [1:0] state_r, state_nxt;

  // Request captured at accept
  logic [1:0]  op_r, op_nxt;
  logic [7:0]  dev_r, dev_nxt;
  logic [31:0] sec_r, sec_nxt;
  logic [3:0]  idx_r, idx_nxt;

  // Per-position compare flags, captured in the match step
  logic [NUM_BUFFERS-1:0] hit_r, hit_nxt;
  logic [NUM_BUFFERS-1:0] free_r, free_nxt;
  logic [NUM_BUFFERS-1:0] addr_r, addr_nxt;

  // Update plan and result, captured in the pick step
  logic [NUM_BUFFERS-1:0] load_r, load_nxt;
  logic [NUM_BUFFERS-1:0] shift_r, shift_nxt;
  entry_t                 bus_r, bus_nxt;
  logic [2:0]             res_status_r, res_status_nxt;
  logic [3:0]             res_idx_r, res_idx_nxt;
  logic                   res_rd_r, res_rd_nxt;
  logic                   res_wr_r, res_wr_nxt;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_status_r, out_status_nxt;
  logic [3:0] out_idx_r, out_idx_nxt;
  logic       out_rd_r, out_rd_nxt;
  logic       out_wr_r, out_wr_nxt;

  entry_t      cell_ent [NUM_BUFFERS];
  cell_flags_t cell_flg [NUM_BUFFERS];
  cell_ctl_t   cell_ctl [NUM_BUFFERS];

  logic [NUM_BUFFERS-1:0] flg_hit, flg_free, flg_addr;
  logic [NUM_BUFFERS-1:0] hit_oh, free_oh;
  logic                   any_hit, any_free;
  logic [NUM_BUFFERS-1:0] front_mask;
  entry_t                 hit_ent, free_ent, addr_ent;
  logic                   in_range;
  logic                   accept;
  logic                   apply_fire;
  logic [CMP_W-1:0]       q_index;

  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign apply_fire = (state_r == S_APPLY) && (!out_valid_r || !out_stall);
  assign q_index    = CMP_W'(idx_r);
  assign in_range   = {1'b0, q_index} < NB_LIMIT;

  // Cell chain: position 0 is the most recent entry
  for (genvar p = 0; p < NUM_BUFFERS; p++) begin : g_cell
    assign cell_ctl[p].shift = apply_fire && shift_r[p];
    assign cell_ctl[p].load  = apply_fire && load_r[p];
    assign flg_hit[p]        = cell_flg[p].hit;
    assign flg_free[p]       = cell_flg[p].free;
    assign flg_addr[p]       = cell_flg[p].addr;

    lbct_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .rst_id   (IDX_W'(NUM_BUFFERS - 1 - p)),
      .ctl      (cell_ctl[p]),
      .prev_ent (cell_ent[(p == 0) ? 0 : p - 1]),
      .bus_ent  (bus_r),
      .q_device (dev_r),
      .q_sector (sec_r),
      .q_index  (q_index),
      .ent      (cell_ent[p]),
      .flags    (cell_flg[p])
    );
  end

  lbct_pick u_pick (
    .hit_v    (hit_r),
    .free_v   (free_r),
    .hit_oh   (hit_oh),
    .free_oh  (free_oh),
    .any_hit  (any_hit),
    .any_free (any_free)
  );

  // Gather the selected entries out of the chain
  always_comb begin
    hit_ent  = '0;
    free_ent = '0;
    addr_ent = '0;
    for (int p = 0; p < NUM_BUFFERS; p++) begin
      hit_ent  = hit_ent  | (hit_oh[p]  ? cell_ent[p] : '0);
      free_ent = free_ent | (free_oh[p] ? cell_ent[p] : '0);
      addr_ent = addr_ent | (addr_r[p]  ? cell_ent[p] : '0);
    end
  end

  // Positions from the front up to and including the addressed one
  assign front_mask = (addr_r - NUM_BUFFERS'(1)) | addr_r;

  // Decide the update and the result from the selected entries
  always_comb begin
    load_nxt       = '0;
    shift_nxt      = '0;
    bus_nxt        = addr_ent;
    res_status_nxt = ST_NOT_BUSY;
    res_idx_nxt    = idx_r;
    res_rd_nxt     = 1'b0;
    res_wr_nxt     = 1'b0;
    unique case (op_r)
      OP_GET: begin
        priority if (any_hit) begin
          res_idx_nxt = idx_out(hit_ent.id);
          if ((hit_ent.marks & MK_BUSY) != '0) begin
            res_status_nxt = ST_WAIT;
          end else begin
            res_status_nxt = ST_HIT;
            res_rd_nxt     = (hit_ent.marks & MK_VALID) == '0;
            bus_nxt        = hit_ent;
            bus_nxt.marks  = hit_ent.marks | MK_BUSY;
            load_nxt       = hit_oh;
          end
        end else if (any_free) begin
          res_status_nxt = ST_RECYCLED;
          res_idx_nxt    = idx_out(free_ent.id);
          res_rd_nxt     = 1'b1;
          bus_nxt.id     = free_ent.id;
          bus_nxt.device = dev_r;
          bus_nxt.sector = sec_r;
          bus_nxt.marks  = MK_BUSY | MK_ASSIGNED;
          load_nxt       = free_oh;
        end else begin
          res_status_nxt = ST_NO_BUF;
          res_idx_nxt    = '0;
        end
      end
      OP_DISK_DONE: begin
        if (in_range) begin
          res_status_nxt = ST_HIT;
          bus_nxt.marks  = (addr_ent.marks | MK_VALID) & ~MK_DIRTY;
          load_nxt       = addr_r;
        end
      end
      OP_RELEASE: begin
        if (in_range && ((addr_ent.marks & MK_BUSY) != '0)) begin
          res_status_nxt = ST_HIT;
          bus_nxt.marks  = addr_ent.marks & ~MK_BUSY;
          load_nxt       = NUM_BUFFERS'(1);
          shift_nxt      = front_mask & ~NUM_BUFFERS'(1);
        end
      end
      OP_WRITE: begin
        if (in_range && ((addr_ent.marks & MK_BUSY) != '0)) begin
          res_status_nxt = ST_HIT;
          res_wr_nxt     = 1'b1;
          bus_nxt.marks  = addr_ent.marks | MK_DIRTY;
          load_nxt       = addr_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer: match, pick, apply
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) begin
        state_nxt = S_MATCH;
      end
      S_MATCH: state_nxt = S_PICK;
      S_PICK:  state_nxt = S_APPLY;
      S_APPLY: if (apply_fire) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt   = accept ? in_op           : op_r;
    dev_nxt  = accept ? in_device       : dev_r;
    sec_nxt  = accept ? in_sector       : sec_r;
    idx_nxt  = accept ? in_buffer_index : idx_r;
    hit_nxt  = (state_r == S_MATCH) ? flg_hit  : hit_r;
    free_nxt = (state_r == S_MATCH) ? flg_free : free_r;
    addr_nxt = (state_r == S_MATCH) ? flg_addr : addr_r;
  end

  // Hold the result while stalled; drop it once taken
  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_rd_nxt     = out_rd_r;
    out_wr_nxt     = out_wr_r;
    if (apply_fire) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_idx_nxt    = res_idx_r;
      out_rd_nxt     = res_rd_r;
      out_wr_nxt     = res_wr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    dev_r        <= dev_nxt;
    sec_r        <= sec_nxt;
    idx_r        <= idx_nxt;
    hit_r        <= hit_nxt;
    free_r       <= free_nxt;
    addr_r       <= addr_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_rd_r     <= out_rd_nxt;
    out_wr_r     <= out_wr_nxt;
  end

  // Update plan is only consumed in the apply step
  always_ff @(posedge clk) begin
    if (state_r == S_PICK) begin
      load_r       <= load_nxt;
      shift_r      <= shift_nxt;
      bus_r        <= bus_nxt;
      res_status_r <= res_status_nxt;
      res_idx_r    <= res_idx_nxt;
      res_rd_r     <= res_rd_nxt;
      res_wr_r     <= res_wr_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_index = out_idx_r;
  assign out_needs_read  = out_rd_r;
  assign out_needs_write = out_wr_r;

endmodule

>>> rtl/core/lbct_chk.sv
// Port-level checker for the buffer cache tag manager, bound to the top level.
module lbct_chk
  import lbct_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [3:0]  out_entry_index,
  input logic        out_needs_read,
  input logic        out_needs_write
);

  // One request in flight: the block closes its input after each accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_NOT_BUSY))
    else $error("status code out of range");

  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_needs_write |-> (out_status == ST_HIT) && !out_needs_read)
    else $error("disk write flagged on a failed request");

  a_no_buf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NO_BUF) |->
      (out_entry_index == 4'd0) && !out_needs_read && !out_needs_write)
    else $error("no-buffer result carries an entry");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_entry_index) && $stable(out_needs_read) && $stable(out_needs_write))
    else $error("stalled result changed");

endmodule

bind lru_buffer_cache_tags lbct_chk u_lbct_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_entry_index (out_entry_index),
  .out_needs_read  (out_needs_read),
  .out_needs_write (out_needs_write)
);

>>> dv/tb.sv
`timescale 1ns / 100ps
// Testbench for lru_buffer_cache_tags: directed table plus random traffic against a tag predictor.
module tb;
  import lbct_pkg::*;

  // Quiet cycles (no transaction on either channel) tolerated before giving up.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int TAIL_ITEMS     = 100;
  localparam int POOL_SIZE      = 24;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  device;
    logic [31:0] sector;
    logic [3:0]  index;
  } cache_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] entry;
    logic       needs_read;
    logic       needs_write;
  } cache_result_t;

  typedef struct packed {
    cache_req_t    req;
    logic          typed;
    cache_result_t want;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = OP_GET;
  logic [7:0]  in_device = '0;
  logic [31:0] in_sector = '0;
  logic [3:0]  in_buffer_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [3:0]  out_entry_index;
  logic        out_needs_read;
  logic        out_needs_write;

  // Predictor copy of the tag store and the recency chain (position 0 = most recent).
  logic [7:0]  tag_device [NUM_BUFFERS];
  logic [31:0] tag_sector [NUM_BUFFERS];
  logic [3:0]  tag_marks  [NUM_BUFFERS];
  int          lru_chain  [NUM_BUFFERS];

  cache_result_t pending_results[$];
  directed_row_t directed_rows[$];
  logic [7:0]    pool_device [POOL_SIZE];
  logic [31:0]   pool_sector [POOL_SIZE];

  int mismatch_count = 0;
  bit tail_phase = 1'b0;

  lru_buffer_cache_tags dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_device       (in_device),
    .in_sector       (in_sector),
    .in_buffer_index (in_buffer_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_needs_read  (out_needs_read),
    .out_needs_write (out_needs_write)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one request to the predictor state and return the result it must produce.
  function automatic cache_result_t cache_predict(input cache_req_t req);
    cache_result_t res;
    int e;
    int pos;
    res = '0;
    if (req.op == OP_GET) begin
      // Most recent matching assigned entry wins; a busy one means wait.
      for (int p = 0; p < NUM_BUFFERS; p++) begin
        e = lru_chain[p];
        if ((tag_marks[e] & MK_ASSIGNED) != 0 && tag_device[e] == req.device &&
            tag_sector[e] == req.sector) begin
          res.entry = 4'(e);
          if ((tag_marks[e] & MK_BUSY) != 0) begin
            res.status = ST_WAIT;
            return res;
          end
          tag_marks[e] = tag_marks[e] | MK_BUSY;
          res.status = ST_HIT;
          res.needs_read = ((tag_marks[e] & MK_VALID) == 0);
          return res;
        end
      end
      // Miss: recycle the least recent entry that is neither busy nor dirty.
      for (int p = NUM_BUFFERS - 1; p >= 0; p--) begin
        e = lru_chain[p];
        if ((tag_marks[e] & (MK_BUSY | MK_DIRTY)) == 0) begin
          tag_device[e] = req.device;
          tag_sector[e] = req.sector;
          tag_marks[e]  = MK_BUSY | MK_ASSIGNED;
          res.status = ST_RECYCLED;
          res.entry = 4'(e);
          res.needs_read = 1'b1;
          return res;
        end
      end
      res.status = ST_NO_BUF;
      return res;
    end
    res.entry = req.index;
    if (int'(req.index) >= NUM_BUFFERS) begin
      res.status = ST_NOT_BUSY;
      return res;
    end
    e = int'(req.index);
    if (req.op == OP_DISK_DONE) begin
      tag_marks[e] = (tag_marks[e] | MK_VALID) & ~MK_DIRTY;
      res.status = ST_HIT;
      return res;
    end
    if ((tag_marks[e] & MK_BUSY) == 0) begin
      res.status = ST_NOT_BUSY;
      return res;
    end
    res.status = ST_HIT;
    if (req.op == OP_RELEASE) begin
      // Move the entry to the front; everything ahead of it slides back by one.
      pos = 0;
      for (int p = 0; p < NUM_BUFFERS; p++) begin
        if (lru_chain[p] == e) begin
          pos = p;
          break;
        end
      end
      for (int p = pos; p > 0; p--) lru_chain[p] = lru_chain[p-1];
      lru_chain[0] = e;
      tag_marks[e] = tag_marks[e] & ~MK_BUSY;
    end else begin
      tag_marks[e] = tag_marks[e] | MK_DIRTY;
      res.needs_write = 1'b1;
    end
    return res;
  endfunction

  // Pick a random entry carrying the given mark; fall back to any entry.
  function automatic logic [3:0] pick_marked(input logic [3:0] mark);
    int hits[$];
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      if ((tag_marks[i] & mark) != 0) hits.push_back(i);
    end
    if (hits.size() == 0 || $urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
    return 4'(hits[$urandom_range(0, hits.size() - 1)]);
  endfunction

  function automatic directed_row_t row(input logic [1:0] op, input logic [7:0] dev,
                                        input logic [31:0] sec, input logic [3:0] idx,
                                        input logic typed, input logic [2:0] st,
                                        input logic [3:0] ent, input logic rd,
                                        input logic wr);
    directed_row_t r;
    r.req  = '{op: op, device: dev, sector: sec, index: idx};
    r.typed = typed;
    r.want = '{status: st, entry: ent, needs_read: rd, needs_write: wr};
    return r;
  endfunction

  // Present one request and hold it until taken; record its expected result at that edge.
  task automatic issue(input cache_req_t req, input logic typed, input cache_result_t want);
    cache_result_t got;
    in_valid        <= 1'b1;
    in_op           <= req.op;
    in_device       <= req.device;
    in_sector       <= req.sector;
    in_buffer_index <= req.index;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = cache_predict(req);
    pending_results.push_back(typed ? want : got);
  endtask

  // Drop valid for a while on the request side.
  task automatic sender_gap(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold valid low until every expected result has drained.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Compare every accepted result against the oldest pending expectation.
  always @(posedge clk) begin
    cache_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d entry_index %0d", out_status, out_entry_index);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          mismatch_count++;
        end
        if (out_entry_index !== want.entry) begin
          $error("entry_index: expected %0d, actual %0d", want.entry, out_entry_index);
          mismatch_count++;
        end
        if (out_needs_read !== want.needs_read) begin
          $error("needs_read: expected %0d, actual %0d", want.needs_read, out_needs_read);
          mismatch_count++;
        end
        if (out_needs_write !== want.needs_write) begin
          $error("needs_write: expected %0d, actual %0d", want.needs_write, out_needs_write);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver back-pressure: free runs (some long) broken by stall bursts, which stop in the tail phase.
  initial begin : receiver_stall
    int run;
    @(posedge clk);
    forever begin
      run = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      if (!tail_phase) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Abort when neither channel moves a transaction for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("lru_buffer_cache_tags verification failed");
    $finish;
  end

  initial begin : stimulus
    cache_req_t    req;
    cache_result_t none;
    bit            gaps_on;
    int            r;
    int            k;
    none = '0;
    gaps_on = 1'b1;

    // Predictor reset: empty cache, position p holds entry NUM_BUFFERS-1-p.
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      tag_device[i] = '0;
      tag_sector[i] = '0;
      tag_marks[i]  = '0;
      lru_chain[i]  = NUM_BUFFERS - 1 - i;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_device[i] = 8'($urandom);
      pool_sector[i] = $urandom;
    end

    // Directed table. Typed rows carry the answer that can be read off directly.
    // Release and write on an idle entry are refused.
    directed_rows.push_back(row(OP_RELEASE, 8'h00, 32'h0, 4'd0, 1, ST_NOT_BUSY, 4'd0, 0, 0));
    directed_rows.push_back(row(OP_WRITE, 8'hFF, 32'hFFFF_FFFF, 4'd15, 1,
                                ST_NOT_BUSY, 4'd15, 0, 0));
    // A zero tag must not match an unassigned entry: recycle the least recent one.
    directed_rows.push_back(row(OP_GET, 8'h00, 32'h0, 4'd0, 1, ST_RECYCLED, 4'd0, 1, 0));
    // Same tag again while busy: wait.
    directed_rows.push_back(row(OP_GET, 8'h00, 32'h0, 4'd0, 1, ST_WAIT, 4'd0, 0, 0));
    directed_rows.push_back(row(OP_WRITE, 8'h00, 32'h0, 4'd0, 1, ST_HIT, 4'd0, 0, 1));
    directed_rows.push_back(row(OP_DISK_DONE, 8'h00, 32'h0, 4'd0, 1, ST_HIT, 4'd0, 0, 0));
    directed_rows.push_back(row(OP_RELEASE, 8'h00, 32'h0, 4'd0, 0, ST_HIT, 4'd0, 0, 0));
    // Clean valid hit, then disk done on an entry that is not busy.
    directed_rows.push_back(row(OP_GET, 8'h00, 32'h0, 4'd0, 0, ST_HIT, 4'd0, 0, 0));
    directed_rows.push_back(row(OP_DISK_DONE, 8'h00, 32'h0, 4'd9, 0, ST_HIT, 4'd9, 0, 0));
    // Fill every other entry with distinct tags, extremes first.
    directed_rows.push_back(row(OP_GET, 8'hFF, 32'hFFFF_FFFF, 4'd0, 0, ST_HIT, 4'd0, 0, 0));
    directed_rows.push_back(row(OP_GET, 8'h00, 32'hFFFF_FFFF, 4'd0, 0, ST_HIT, 4'd0, 0, 0));
    directed_rows.push_back(row(OP_GET, 8'hFF, 32'h0, 4'd0, 0, ST_HIT, 4'd0, 0, 0));
    directed_rows.push_back(row(OP_GET, 8'h80, 32'h8000_0000, 4'd0, 0, ST_HIT, 4'd0, 0, 0));
    for (int i = 1; i <= 11; i++) begin
      directed_rows.push_back(row(OP_GET, 8'(i), $urandom, 4'd0, 0, ST_HIT, 4'd0, 0, 0));
    end
    // Everything busy now: no buffer to hand out.
    directed_rows.push_back(row(OP_GET, 8'h5A, 32'h1, 4'd0, 1, ST_NO_BUF, 4'd0, 0, 0));
    directed_rows.push_back(row(OP_RELEASE, 8'h00, 32'h0, 4'd15, 0, ST_HIT, 4'd0, 0, 0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      if ($urandom_range(0, 2) == 0) sender_gap($urandom_range(1, 13));
    end

    // Let the directed part drain completely before random traffic starts.
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - TAIL_ITEMS) tail_phase = 1'b1;
      if (n % 64 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (n == RANDOM_ITEMS / 2) drain_results();

      // Mostly well-formed traffic: gets from a small tag pool so hits and waits
      // happen, releases and writes aimed at busy entries, disk done at dirty ones.
      req.device = 8'($urandom);
      req.sector = $urandom;
      req.index  = 4'($urandom_range(0, 15));
      r = $urandom_range(0, 99);
      if (r < 40) begin
        req.op = OP_GET;
        if ($urandom_range(0, 9) != 0) begin
          k = $urandom_range(0, POOL_SIZE - 1);
          req.device = pool_device[k];
          req.sector = pool_sector[k];
        end
      end else if (r < 65) begin
        req.op = OP_RELEASE;
        req.index = pick_marked(MK_BUSY);
      end else if (r < 77) begin
        req.op = OP_WRITE;
        req.index = pick_marked(MK_BUSY);
      end else if (r < 92) begin
        req.op = OP_DISK_DONE;
        req.index = pick_marked(MK_DIRTY);
      end else begin
        req.op = 2'($urandom_range(0, 3));
      end

      issue(req, 1'b0, none);
      if (!tail_phase && gaps_on && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 13));
    end

    // Wait out every pending result, then a few cycles for stray output.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("lru_buffer_cache_tags verification clean");
    end else begin
      $display("lru_buffer_cache_tags verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/lbct_pkg.sv
rtl/core/lbct_cell.sv
rtl/core/lbct_pick.sv
rtl/core/lru_buffer_cache_tags.sv
rtl/core/lbct_chk.sv
dv/tb.sv
